// ----- sv/bqop_pkg.sv -----
// Package for the bounded request queue with overload policy.
// Holds payload structs, opcode/status/policy codes and sizing constants.
// No dependencies.
package bqop_pkg;

   localparam int ID_WIDTH       = 16;
   localparam int COUNT_WIDTH    = 7;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 7;
   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int MAX_REQ_RESET  = 64;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_DONE = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_REFUSED   = 3'd1,
      ST_DROP_NEW  = 3'd2,
      ST_DROP_OLD  = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      POL_BLOCK     = 2'd0,
      POL_DROP_TAIL = 2'd1,
      POL_DROP_HEAD = 2'd2,
      POL_RSVD      = 2'd3
   } policy_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_POLICY = 2'd0,
      CSR_LIMIT  = 2'd1
   } csr_index_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [ID_WIDTH-1:0] request_id;
   } req_payload_type;

   typedef struct packed {
      status_type             status;
      logic [ID_WIDTH-1:0]    out_id;
      logic [COUNT_WIDTH-1:0] waiting_count;
      logic [COUNT_WIDTH-1:0] in_service_count;
   } rsp_payload_type;

endpackage

// ----- sv/bounded_queue_overload_policy_unit.sv -----
// Bounded request queue with admission control: top level.
// Depends on bqop_pkg; the id ring is a one-port-read, one-port-write sync memory.
//
// Every accepted request (push, pop, done, nop) yields exactly one response.
// The response passes through stage 1, which covers the ring read, and then
// the response register, which loads when the response side is free. One
// request per cycle is sustained while req_stall is low: all admission
// decisions come from the pointer and counter registers, and the single ring
// read port (registered data) is used by pop and drop-oldest pushes. req_stall
// rises only while the read stage is occupied and the response register is
// held by rsp_stall. The id ring needs no clearing after reset.
// Configuration writes are always taken (csr_ready high); writes to the
// request limit saturate at QUEUE_DEPTH.
module bounded_queue_overload_policy_unit
   import bqop_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [COUNT_WIDTH-1:0] LIMIT_RST = (QUEUE_DEPTH < MAX_REQ_RESET) ?
      COUNT_WIDTH'(QUEUE_DEPTH) : COUNT_WIDTH'(MAX_REQ_RESET);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // configuration
   policy_type             policy_ff;
   logic [COUNT_WIDTH-1:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_BLOCK;
         limit_ff  <= LIMIT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_POLICY: begin
               policy_ff <= policy_type'(csr_wdata[1:0]);
            end
            CSR_LIMIT: begin
               if (32'(csr_wdata) > 32'(QUEUE_DEPTH)) begin
                  limit_ff <= COUNT_WIDTH'(QUEUE_DEPTH);
               end else begin
                  limit_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // queue state
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [COUNT_WIDTH-1:0] wait_ff, wait_in;
   logic [COUNT_WIDTH-1:0] serv_ff, serv_in;

   // stage 1 (memory read in flight) and response register
   logic                   s1_valid_ff, s1_valid_in;
   status_type             s1_status_ff, s1_status_in;
   logic                   s1_take_ff, s1_take_in;
   logic [ID_WIDTH-1:0]    s1_id_ff, s1_id_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;

   logic [ID_WIDTH-1:0]    ring_mem [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0]    rd_data_ff;

   logic                   req_acc;
   logic                   s1_adv;
   logic                   full;
   logic                   do_put;
   logic                   do_take;
   logic [COUNT_WIDTH:0]   total;

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   assign total = {1'b0, wait_ff} + {1'b0, serv_ff};
   assign full  = total >= {1'b0, limit_ff};

   always_comb begin
      do_put       = 1'b0;
      do_take      = 1'b0;
      s1_status_in = ST_OK;
      s1_id_in     = '0;
      serv_in      = serv_ff;
      case (req_payload.opcode)
         OP_PUSH: begin
            if (!full) begin
               do_put = 1'b1;
            end else begin
               case (policy_ff)
                  POL_DROP_TAIL: begin
                     s1_status_in = ST_DROP_NEW;
                     s1_id_in     = req_payload.request_id;
                  end
                  POL_DROP_HEAD: begin
                     if (wait_ff == '0) begin
                        s1_status_in = ST_DROP_NEW;
                        s1_id_in     = req_payload.request_id;
                     end else begin
                        s1_status_in = ST_DROP_OLD;
                        do_take      = 1'b1;
                        do_put       = 1'b1;
                     end
                  end
                  default: begin
                     s1_status_in = ST_REFUSED;
                  end
               endcase
            end
         end
         OP_POP: begin
            if (wait_ff == '0) begin
               s1_status_in = ST_EMPTY;
            end else begin
               do_take = 1'b1;
               serv_in = serv_ff + 1'b1;
            end
         end
         OP_DONE: begin
            if (serv_ff == '0) begin
               s1_status_in = ST_UNDERFLOW;
            end else begin
               serv_in = serv_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      s1_take_in = do_take;
      rd_ptr_in  = do_take ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in  = do_put  ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      wait_in    = wait_ff + COUNT_WIDTH'(do_put) - COUNT_WIDTH'(do_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         wait_ff   <= '0;
         serv_ff   <= '0;
      end else if (req_acc) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         wait_ff   <= wait_in;
         serv_ff   <= serv_in;
      end
   end

   // ring memory: read returns the old entry on a same-address write
   always_ff @(posedge clock) begin
      if (req_acc && do_put) begin
         ring_mem[wr_ptr_ff] <= req_payload.request_id;
      end
      if (req_acc && do_take) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   assign s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = (s1_valid_ff && s1_adv) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      rsp_payload_in.status           = s1_status_ff;
      rsp_payload_in.out_id           = s1_take_ff ? rd_data_ff : s1_id_ff;
      rsp_payload_in.waiting_count    = wait_ff;
      rsp_payload_in.in_service_count = serv_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_status_ff <= s1_status_in;
         s1_take_ff   <= s1_take_in;
         s1_id_ff     <= s1_id_in;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- sv/bqop_checker.sv -----
// Port-level checker for the bounded request queue, bound to the top level.
// Depends on bqop_pkg and bounded_queue_overload_policy_unit.
module bqop_checker
   import bqop_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_payload_type           rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == ST_REFUSED || rsp_payload.status == ST_EMPTY ||
                    rsp_payload.status == ST_UNDERFLOW) |-> rsp_payload.out_id == '0)
      else $error("nonzero id on a failed transfer");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_EMPTY |-> rsp_payload.waiting_count == '0)
      else $error("empty reported with waiting requests");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_UNDERFLOW |->
         rsp_payload.in_service_count == '0)
      else $error("underflow reported with requests in service");

endmodule

bind bounded_queue_overload_policy_unit bqop_checker u_bqop_checker (.*);
